// ===== rtl/rpaf_pkg.sv =====
// ----------------------------------------------------------------------------
// rpaf_pkg
// Shared widths, command and status codes, and the control/status bundles
// passed between the ring pool allocator controller and its datapath.
// ----------------------------------------------------------------------------
package rpaf_pkg;

	// Fixed field widths of the item ports
	localparam int CMD_W      = 2;
	localparam int DREF_W     = 16;
	localparam int RINGLESS_W = 8;
	localparam int PIDX_W     = 6;
	localparam int STATUS_W   = 3;
	localparam int GIDX_W     = 5;
	localparam int RCNT_W     = 6;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_ACQUIRE     = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RELEASE     = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RELEASE_ALL = 2'd2;
	localparam logic [CMD_W-1:0] CMD_UNUSED      = 2'd3;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_PARAM = 3'd1;
	localparam logic [STATUS_W-1:0] ST_AT_CAP    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_UNFAIR    = 3'd4;

	// Release-all count saturates here
	localparam logic [RCNT_W-1:0] RCNT_MAX = 6'd63;

	// Controller -> datapath commands
	typedef struct packed {
		logic load;        // latch item fields, preset result to bad parameter
		logic scan_start;  // walk the whole owner table
		logic rd_one;      // read the entry named by pool_index
		logic chk_one;     // evaluate single release
		logic decide;      // final acquire / release-all outcome
		logic publish;     // move result into the output register
	} rpaf_ctl_t;

	// Datapath -> controller status
	typedef struct packed {
		logic             in_bad;     // presented item fails parameter checks
		logic [CMD_W-1:0] in_cmd;     // presented command
		logic             scan_done;  // last table entry evaluated
		logic             out_busy;   // output register full and stalled
	} rpaf_sts_t;

endpackage

// ===== rtl/rpaf_ctrl.sv =====
// ----------------------------------------------------------------------------
// rpaf_ctrl
// Command sequencer: steps one item through pre-check, table scan or single
// read, the decision and the hand-off to the output register.
// ----------------------------------------------------------------------------
module rpaf_ctrl
	import rpaf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  rpaf_sts_t sts,
	output rpaf_ctl_t ctl
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_SCAN   = 6'b000010,
		S_READ   = 6'b000100,
		S_CHECK  = 6'b001000,
		S_DECIDE = 6'b010000,
		S_DONE   = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.load = 1'b1;
					if (sts.in_bad) begin
						state_d = S_DONE;
					end else if (sts.in_cmd == CMD_RELEASE) begin
						state_d = S_READ;
					end else begin
						ctl.scan_start = 1'b1;
						state_d        = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (sts.scan_done) begin
					state_d = S_DECIDE;
				end
			end
			S_READ: begin
				ctl.rd_one = 1'b1;
				state_d    = S_CHECK;
			end
			S_CHECK: begin
				ctl.chk_one = 1'b1;
				state_d     = S_DONE;
			end
			S_DECIDE: begin
				ctl.decide = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					ctl.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/rpaf_dpath.sv =====
// ----------------------------------------------------------------------------
// rpaf_dpath
// Owner table (memory plus occupied bits), scan counters, decision logic and
// the result / output registers.
// ----------------------------------------------------------------------------
module rpaf_dpath
	import rpaf_pkg::*;
#(
	parameter int POOL_RINGS = 32,
	parameter int DEVICE_CAP = 4,
	parameter int REF_BITS   = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [CMD_W-1:0]      cmd,
	input  logic [DREF_W-1:0]     device_ref,
	input  logic [RINGLESS_W-1:0] ringless,
	input  logic [PIDX_W-1:0]     pool_index,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [STATUS_W-1:0]   status,
	output logic [GIDX_W-1:0]     granted_index,
	output logic [RCNT_W-1:0]     released_count,
	input  rpaf_ctl_t             ctl,
	output rpaf_sts_t             sts
);

	localparam int IDX_W = (POOL_RINGS > 1) ? $clog2(POOL_RINGS) : 1;
	localparam int CNT_W = $clog2(POOL_RINGS + 1);
	localparam int CMP_W = (CNT_W > RINGLESS_W) ? CNT_W : RINGLESS_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_RINGS - 1);

	// Owner table: data in memory, occupancy in flops (free == not occupied)
	logic [REF_BITS-1:0] mem_q [POOL_RINGS];
	logic [POOL_RINGS-1:0] vld_q;

	// Latched item
	logic [CMD_W-1:0]      cmd_q;
	logic [REF_BITS-1:0]   ref_q;
	logic [RINGLESS_W-1:0] ringless_q;
	logic [PIDX_W-1:0]     idx_q;

	// Scan and read pipe
	logic             scan_active_q;
	logic [IDX_W-1:0] scan_cnt_q;
	logic             rd_req;
	logic [IDX_W-1:0] raddr;
	logic             rd_live_s1;
	logic             rd_scan_s1;
	logic             rd_last_s1;
	logic [IDX_W-1:0] rd_addr_s1;
	logic [REF_BITS-1:0] rd_data_s1;
	logic             rd_vld_s1;

	// Scan accumulators
	logic [CNT_W-1:0] held_q;
	logic [CNT_W-1:0] free_q;
	logic [IDX_W-1:0] ffree_q;
	logic             ffound_q;

	// Result and output registers
	logic [STATUS_W-1:0] res_status_q;
	logic [GIDX_W-1:0]   res_granted_q;
	logic [RCNT_W-1:0]   res_released_q;
	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [GIDX_W-1:0]   out_granted_q;
	logic [RCNT_W-1:0]   out_released_q;

	logic [REF_BITS-1:0] in_ref;
	logic                in_range;
	logic                hit;
	logic                scan_eval;
	logic                at_cap;
	logic                unfair;
	logic                grant;
	logic                one_hit;
	logic [STATUS_W-1:0] acq_status;
	logic [RCNT_W-1:0]   rel_sat;

	// Pre-check on the presented item
	assign in_ref   = REF_BITS'(device_ref);
	assign in_range = (32'(pool_index) < POOL_RINGS);

	assign sts.in_bad = (in_ref == '0) || (cmd == CMD_UNUSED) ||
		((cmd == CMD_RELEASE) && !in_range);
	assign sts.in_cmd    = cmd;
	assign sts.scan_done = rd_live_s1 && rd_last_s1;
	assign sts.out_busy  = out_valid_q && out_stall;

	// Read port address
	assign rd_req = scan_active_q || ctl.rd_one;
	assign raddr  = scan_active_q ? scan_cnt_q : IDX_W'(idx_q);

	assign hit       = rd_vld_s1 && (rd_data_s1 == ref_q);
	assign scan_eval = rd_live_s1 && rd_scan_s1;
	assign one_hit   = ctl.chk_one && hit;

	// Acquire decision
	assign at_cap = (32'(held_q) >= DEVICE_CAP);
	assign unfair = (held_q != '0) &&
		((CMP_W'(free_q) - CMP_W'(1)) < CMP_W'(ringless_q));

	always_comb begin
		if (at_cap) begin
			acq_status = ST_AT_CAP;
		end else if (free_q == '0) begin
			acq_status = ST_EMPTY;
		end else if (unfair) begin
			acq_status = ST_UNFAIR;
		end else begin
			acq_status = ST_OK;
		end
	end

	assign grant   = ctl.decide && (cmd_q == CMD_ACQUIRE) && (acq_status == ST_OK);
	assign rel_sat = (32'(held_q) > 32'(RCNT_MAX)) ? RCNT_MAX : RCNT_W'(held_q);

	// Item latch
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q      <= cmd;
			ref_q      <= in_ref;
			ringless_q <= ringless;
			idx_q      <= pool_index;
		end
	end

	// Scan sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_active_q <= 1'b0;
			scan_cnt_q    <= '0;
			rd_live_s1    <= 1'b0;
			rd_scan_s1    <= 1'b0;
			rd_last_s1    <= 1'b0;
		end else begin
			if (ctl.scan_start) begin
				scan_active_q <= 1'b1;
				scan_cnt_q    <= '0;
			end else if (scan_active_q) begin
				if (scan_cnt_q == LAST_IDX) begin
					scan_active_q <= 1'b0;
				end
				scan_cnt_q <= scan_cnt_q + IDX_W'(1);
			end
			rd_live_s1 <= rd_req;
			rd_scan_s1 <= scan_active_q;
			rd_last_s1 <= scan_active_q && (scan_cnt_q == LAST_IDX);
		end
	end

	// Table memory: registered read, single write on grant
	always_ff @(posedge clk) begin
		if (rd_req) begin
			rd_data_s1 <= mem_q[raddr];
			rd_vld_s1  <= vld_q[raddr];
			rd_addr_s1 <= raddr;
		end
		if (grant) begin
			mem_q[ffree_q] <= ref_q;
		end
	end

	// Occupied bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (scan_eval && hit && (cmd_q == CMD_RELEASE_ALL)) begin
				vld_q[rd_addr_s1] <= 1'b0;
			end
			if (one_hit) begin
				vld_q[IDX_W'(idx_q)] <= 1'b0;
			end
			if (grant) begin
				vld_q[ffree_q] <= 1'b1;
			end
		end
	end

	// Held / free counts and lowest free index
	always_ff @(posedge clk) begin
		if (ctl.scan_start) begin
			held_q   <= '0;
			free_q   <= '0;
			ffree_q  <= '0;
			ffound_q <= 1'b0;
		end else if (scan_eval) begin
			if (hit) begin
				held_q <= held_q + CNT_W'(1);
			end
			if (!rd_vld_s1) begin
				free_q <= free_q + CNT_W'(1);
				if (!ffound_q) begin
					ffree_q  <= rd_addr_s1;
					ffound_q <= 1'b1;
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			res_status_q   <= ST_BAD_PARAM;
			res_granted_q  <= '0;
			res_released_q <= '0;
		end else if (one_hit) begin
			res_status_q <= ST_OK;
		end else if (ctl.decide) begin
			if (cmd_q == CMD_RELEASE_ALL) begin
				res_status_q   <= ST_OK;
				res_released_q <= rel_sat;
			end else begin
				res_status_q  <= acq_status;
				res_granted_q <= grant ? GIDX_W'(ffree_q) : '0;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.publish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.publish) begin
			out_status_q   <= res_status_q;
			out_granted_q  <= res_granted_q;
			out_released_q <= res_released_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign granted_index  = out_granted_q;
	assign released_count = out_released_q;

endmodule

// ===== rtl/ring_pool_allocator_fair_core.sv =====
// ----------------------------------------------------------------------------
// ring_pool_allocator_fair_core
// Ring pool allocator with a per-device cap and a fairness admission rule.
// ----------------------------------------------------------------------------
// The block keeps an owner table of POOL_RINGS entries, all free after reset,
// and handles one item at a time: acquire, release one ring, or release all
// rings of a device, each giving exactly one result item. Acquire and
// release-all walk the whole table through the single read port of the owner
// memory, one entry per cycle, and then decide; release of one ring reads and
// checks only its own entry, and an item that fails its parameter checks goes
// straight to the output hand-off. A finished result sits in an output
// register, so the next item is accepted while it waits to be taken; the
// block only holds stall high while an item is being worked on, or while a
// new result is ready and the previous one has not yet left.
// ----------------------------------------------------------------------------
module ring_pool_allocator_fair_core
	import rpaf_pkg::*;
#(
	parameter int POOL_RINGS = 32,
	parameter int DEVICE_CAP = 4,
	parameter int REF_BITS   = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,

	// Command item channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [CMD_W-1:0]      cmd,
	input  logic [DREF_W-1:0]     device_ref,
	input  logic [RINGLESS_W-1:0] ringless,
	input  logic [PIDX_W-1:0]     pool_index,

	// Result item channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [STATUS_W-1:0]   status,
	output logic [GIDX_W-1:0]     granted_index,
	output logic [RCNT_W-1:0]     released_count
);

	rpaf_ctl_t ctl;
	rpaf_sts_t sts;

	// Sequencer: idle -> (scan -> decide | single read -> check) -> hand-off
	rpaf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.ctl      (ctl)
	);

	// Owner table, counters, decision and output registers
	rpaf_dpath #(
		.POOL_RINGS (POOL_RINGS),
		.DEVICE_CAP (DEVICE_CAP),
		.REF_BITS   (REF_BITS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.device_ref     (device_ref),
		.ringless       (ringless),
		.pool_index     (pool_index),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.granted_index  (granted_index),
		.released_count (released_count),
		.ctl            (ctl),
		.sts            (sts)
	);

endmodule
